@@ hdl/rsv_pkg.sv @@
// Shared types and constants for the rotated array search block.
`timescale 1ns / 1ps
`default_nettype none

package rsv_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_CMP,
    ST_CHK,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic set_ovf;
    logic capture_key;
    logic init1;
    logic init2;
    logic rd_mid;
    logic rd_lo;
    logic step;
    logic set_hit;
    logic set_miss;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic lo_lt_hi;
    logic lo_lt_fin;
    logic first_lt_count;
    logic eq;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ hdl/rsv_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsv_dp.sv @@
// Datapath of the rotated array search: element store, run bounds, search pointers and output register.
`timescale 1ns / 1ps
`default_nettype none

module rsv_dp
  import rsv_pkg::*;
#(
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [VALUE_W-1:0] in_value,
  input  wire cmd_t               cmd,
  output sts_t                    sts,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic                    out_found,
  output logic [POS_W-1:0]        out_position,
  output logic                    out_overflow
);

  logic [CW-1:0]      count;
  logic [AW-1:0]      run_end;
  logic               seen;
  logic [VALUE_W-1:0] prev;
  logic [VALUE_W-1:0] key;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic [CW-1:0]      fin;
  logic               res_found;
  logic [POS_W-1:0]   res_position;
  logic               res_overflow;

  logic [CW-1:0]      first_end;
  logic [CW-1:0]      run_end_inc;
  logic [CW-1:0]      mid;
  logic [CW-1:0]      lo_inc;
  logic [VALUE_W-1:0] rdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  logic               descent;

  assign run_end_inc = CW'(run_end) + CW'(1);
  assign first_end   = (seen && (run_end_inc < count)) ? run_end_inc : count;
  assign mid         = lo + ((hi - lo) >> 1);
  assign lo_inc      = lo + CW'(1);
  assign descent     = (count != '0) && ($signed(in_value) < $signed(prev));

  assign ram_re    = cmd.rd_mid || cmd.rd_lo;
  assign ram_raddr = cmd.rd_mid ? mid[AW-1:0] : lo[AW-1:0];

  rsv_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.append),
    .waddr(count[AW-1:0]),
    .wdata(in_value),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  always_comb begin
    sts.full           = (count == CW'(DEPTH));
    sts.lo_lt_hi       = (lo < hi);
    sts.lo_lt_fin      = (lo < fin);
    sts.first_lt_count = (first_end < count);
    sts.eq             = (rdata == key);
    sts.out_free       = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      run_end <= '0;
      seen    <= 1'b0;
    end else if (cmd.clear) begin
      count   <= '0;
      run_end <= '0;
      seen    <= 1'b0;
    end else if (cmd.append) begin
      if (descent) begin
        run_end <= AW'(count - CW'(1));
        seen    <= 1'b1;
      end
      count <= count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      prev <= in_value;
    end
    if (cmd.capture_key) begin
      key <= in_value;
    end
    if (cmd.init1) begin
      lo  <= '0;
      hi  <= first_end;
      fin <= first_end;
    end else if (cmd.init2) begin
      lo  <= first_end;
      hi  <= count;
      fin <= count;
    end else if (cmd.step) begin
      if ($signed(rdata) < $signed(key)) begin
        lo <= mid + CW'(1);
      end else begin
        hi <= mid;
      end
    end
    if (cmd.set_hit) begin
      res_found    <= 1'b1;
      res_position <= POS_W'(lo_inc);
      res_overflow <= 1'b0;
    end else if (cmd.set_miss) begin
      res_found    <= 1'b0;
      res_position <= '0;
      res_overflow <= 1'b0;
    end else if (cmd.set_ovf) begin
      res_found    <= 1'b0;
      res_position <= '0;
      res_overflow <= 1'b1;
    end
    if (cmd.out_load) begin
      out_found    <= res_found;
      out_position <= res_position;
      out_overflow <= res_overflow;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsv_ctrl.sv @@
// Controller state machine that sequences appends, clears and the two binary searches.
`timescale 1ns / 1ps
`default_nettype none

module rsv_ctrl
  import rsv_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 in_ready,
  input  wire sts_t            sts,
  output cmd_t                 cmd
);

  state_t state;
  state_t state_next;
  logic   run2;
  logic   run2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      run2  <= 1'b0;
    end else begin
      state <= state_next;
      run2  <= run2_next;
    end
  end

  always_comb begin
    state_next = state;
    run2_next  = run2;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_CLEAR: begin
              cmd.clear = 1'b1;
            end
            OP_APPEND: begin
              if (sts.full) begin
                cmd.set_ovf = 1'b1;
                state_next  = ST_DONE;
              end else begin
                cmd.append = 1'b1;
              end
            end
            OP_QUERY: begin
              cmd.capture_key = 1'b1;
              cmd.init1       = 1'b1;
              run2_next       = 1'b0;
              state_next      = ST_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD: begin
        if (sts.lo_lt_hi) begin
          cmd.rd_mid = 1'b1;
          state_next = ST_CMP;
        end else if (sts.lo_lt_fin) begin
          cmd.rd_lo  = 1'b1;
          state_next = ST_CHK;
        end else if (!run2 && sts.first_lt_count) begin
          cmd.init2 = 1'b1;
          run2_next = 1'b1;
        end else begin
          cmd.set_miss = 1'b1;
          state_next   = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd.step   = 1'b1;
        state_next = ST_RD;
      end
      ST_CHK: begin
        if (sts.eq) begin
          cmd.set_hit = 1'b1;
          state_next  = ST_DONE;
        end else if (!run2 && sts.first_lt_count) begin
          cmd.init2  = 1'b1;
          run2_next  = 1'b1;
          state_next = ST_RD;
        end else begin
          cmd.set_miss = 1'b1;
          state_next   = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/rotated_array_search.sv @@
// Top level of the rotated array search block.
//
//   Channel  Direction  Signals                   Contents
//   s        in         s_tvalid/tready/tdata/tuser  value in tdata, op in tuser
//   m        out        m_tvalid/tready/tdata/tuser  found and position in tdata, overflow in tuser
//
// A clear or an accepted append completes in the idle state. A full-store append sets an
// overflow result that waits in the done state until the output register is free. A query
// runs up to two binary searches of the store RAM, each probe a read state and a compare state.
// Reset clears the count, the descent mark and the output valid flag.
// The output register lets a new transaction enter while a result waits to be taken.
`timescale 1ns / 1ps
`default_nettype none

module rotated_array_search
  import rsv_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // value[31:0]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // found[0], position[11:1], zero fill[15:12]
  output logic [0:0]       m_tuser    // overflow[0]
);

  cmd_t             cmd;
  sts_t             sts;
  logic             out_found;
  logic [POS_W-1:0] out_position;
  logic             out_overflow;

  rsv_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_op   (s_tuser),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  rsv_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_value    (s_tdata),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_found   (out_found),
    .out_position(out_position),
    .out_overflow(out_overflow)
  );

  assign m_tdata = {4'b0000, out_position, out_found};
  assign m_tuser = out_overflow;

endmodule

`default_nettype wire

@@ hdl/rsv_checker.sv @@
// Port-level assertions for the rotated array search block and their bind.
`timescale 1ns / 1ps
`default_nettype none

module rsv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata,
  input wire logic [0:0]  m_tuser
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
    else $error("input transaction changed or vanished while waiting");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed or vanished while stalled");

  a_ovf_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[11:0] == 12'd0)
    else $error("overflow result carries a match");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[11:1] == 11'd0)
    else $error("not-found result carries a position");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

bind rotated_array_search rsv_checker u_rsv_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tdata (s_tdata),
  .s_tuser (s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tuser (m_tuser)
);

`default_nettype wire
